// ===== rtl/rcpwd_pkg.sv =====
// Shared types and constants for the RC servo pulse width decoder.
// No dependencies; imported by rcpwd_core and rc_pulse_width_decoder_top.
package rcpwd_pkg;

  localparam int NUM_CHANNELS      = 4;
  localparam int CHANNEL_W         = 2;
  localparam int TICK_W            = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int ENABLE_W          = NUM_CHANNELS;

  // s_axis tdata: channel, timestamp, pin_level, padded to whole bytes
  localparam int IN_FIELDS_W = CHANNEL_W + TICK_W + 1;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TS_LSB   = CHANNEL_W;
  localparam int IN_LVL_BIT  = CHANNEL_W + TICK_W;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEGAL_LOW  = 3'd0,
    REG_LEGAL_HIGH = 3'd1,
    REG_SPAN_LOW   = 3'd2,
    REG_SPAN_HIGH  = 3'd3,
    REG_ENABLE     = 3'd4,
    REG_INVERT     = 3'd5
  } cfg_index_t;

  localparam logic [TICK_W-1:0]   LEGAL_LOW_RST  = 32'd500;
  localparam logic [TICK_W-1:0]   LEGAL_HIGH_RST = 32'd2500;
  localparam logic [TICK_W-1:0]   SPAN_LOW_RST   = 32'd1000;
  localparam logic [TICK_W-1:0]   SPAN_HIGH_RST  = 32'd2000;
  localparam logic [ENABLE_W-1:0] ENABLE_RST     = 4'hF;

  typedef struct packed {
    logic [TICK_W-1:0]   legal_low;
    logic [TICK_W-1:0]   legal_high;
    logic [TICK_W-1:0]   span_low;
    logic [TICK_W-1:0]   span_high;
    logic [ENABLE_W-1:0] channel_enable;
    logic                invert_level;
  } cfg_regs_t;

  // One completed pulse handed to the measurement core
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [TICK_W-1:0]    timestamp;
    logic [TICK_W-1:0]    last_time;
  } job_t;

  typedef enum logic [3:0] {
    CORE_IDLE,
    CORE_WIDTH,
    CORE_CHK_LO,
    CORE_CHK_HI,
    CORE_RANGE,
    CORE_CLAMP_LO,
    CORE_CLAMP_HI,
    CORE_OFFSET,
    CORE_DIV,
    CORE_DONE
  } core_state_t;

endpackage

// ===== rtl/rcpwd_core.sv =====
// Pulse measurement core: one shared 33-bit subtractor under a sequencer does
// width, window checks, clamp and a restoring divide. Depends on rcpwd_pkg.
module rcpwd_core #(
  parameter int FRACTION_BITS = rcpwd_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rcpwd_pkg::cfg_regs_t             cfg,
  input  logic                             start,
  input  rcpwd_pkg::job_t                  job,
  output logic                             idle,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [rcpwd_pkg::CHANNEL_W-1:0]  res_channel,
  output logic [FRACTION_BITS:0]           res_fraction
);
  import rcpwd_pkg::*;

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  core_state_t          state, state_next;
  logic [TICK_W-1:0]    w, w_next;
  logic [TICK_W-1:0]    rng, rng_next;
  logic [TICK_W:0]      rem, rem_next;
  logic [FRACTION_BITS:0] quo, quo_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [CHANNEL_W-1:0] ch, ch_next;

  // shared subtractor
  logic [TICK_W:0]   op_a, op_b;
  logic [TICK_W+1:0] diff;
  logic              borrow;
  logic [TICK_W:0]   div_rem;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      CORE_WIDTH:    begin op_a = {1'b0, w};              op_b = rem;                     end
      CORE_CHK_LO:   begin op_a = {1'b0, w};              op_b = {1'b0, cfg.legal_low};   end
      CORE_CHK_HI:   begin op_a = {1'b0, cfg.legal_high}; op_b = {1'b0, w};               end
      CORE_RANGE:    begin op_a = {1'b0, cfg.span_high};  op_b = {1'b0, cfg.span_low};    end
      CORE_CLAMP_LO: begin op_a = {1'b0, w};              op_b = {1'b0, cfg.span_low};    end
      CORE_CLAMP_HI: begin op_a = {1'b0, cfg.span_high};  op_b = {1'b0, w};               end
      CORE_OFFSET:   begin op_a = {1'b0, w};              op_b = {1'b0, cfg.span_low};    end
      CORE_DIV:      begin op_a = rem;                    op_b = {1'b0, rng};             end
      default: ;
    endcase
  end

  assign diff    = {1'b0, op_a} - {1'b0, op_b};
  assign borrow  = diff[TICK_W+1];
  assign div_rem = borrow ? rem : diff[TICK_W:0];

  always_comb begin
    state_next = state;
    w_next     = w;
    rng_next   = rng;
    rem_next   = rem;
    quo_next   = quo;
    cnt_next   = cnt;
    ch_next    = ch;
    unique case (state)
      CORE_IDLE: begin
        if (start) begin
          w_next     = job.timestamp;
          rem_next   = {1'b0, job.last_time};
          ch_next    = job.channel;
          state_next = CORE_WIDTH;
        end
      end
      CORE_WIDTH: begin
        w_next     = diff[TICK_W-1:0];  // modulo 2^32 width
        state_next = CORE_CHK_LO;
      end
      CORE_CHK_LO: begin
        state_next = borrow ? CORE_IDLE : CORE_CHK_HI;
      end
      CORE_CHK_HI: begin
        state_next = borrow ? CORE_IDLE : CORE_RANGE;
      end
      CORE_RANGE: begin
        if (borrow || (diff[TICK_W-1:0] == '0)) begin
          quo_next   = '0;  // empty or inverted span
          state_next = CORE_DONE;
        end else begin
          rng_next   = diff[TICK_W-1:0];
          state_next = CORE_CLAMP_LO;
        end
      end
      CORE_CLAMP_LO: begin
        if (borrow) w_next = cfg.span_low;
        state_next = CORE_CLAMP_HI;
      end
      CORE_CLAMP_HI: begin
        if (borrow) w_next = cfg.span_high;
        state_next = CORE_OFFSET;
      end
      CORE_OFFSET: begin
        rem_next   = diff[TICK_W:0];  // offset <= range, so first quotient bit is 0 or 1
        quo_next   = '0;
        cnt_next   = CNT_W'(FRACTION_BITS);
        state_next = CORE_DIV;
      end
      CORE_DIV: begin
        // remainder stays below range, so the shifted value fits 33 bits
        rem_next = {div_rem[TICK_W-1:0], 1'b0};
        quo_next = {quo[FRACTION_BITS-1:0], ~borrow};
        if (cnt == '0) begin
          state_next = CORE_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      CORE_DONE: begin
        if (res_ready) state_next = CORE_IDLE;
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    w   <= w_next;
    rng <= rng_next;
    rem <= rem_next;
    quo <= quo_next;
    cnt <= cnt_next;
    ch  <= ch_next;
  end

  assign idle         = (state == CORE_IDLE);
  assign res_valid    = (state == CORE_DONE);
  assign res_channel  = ch;
  assign res_fraction = quo;

endmodule

// ===== rtl/rc_pulse_width_decoder_top.sv =====
// Top level of the RC servo pulse width decoder: config registers, per-channel
// edge state, stream handshakes and output register. Uses rcpwd_pkg, rcpwd_core.
//
//  channel   dir  fields (tdata/index, lowest bit up)
//  s_axis    in   channel[1:0], timestamp[33:2], pin_level[34]
//  m_axis    out  out_channel[1:0], fraction[FRACTION_BITS+2:2]
//  cfg       in   cfg_index selects register 0..5, cfg_data holds the value
//
// Capture events that complete no pulse are taken whenever the core is idle. A
// completed pulse occupies the shared subtractor for at most 7 setup steps
// plus FRACTION_BITS+1 divide steps and then a handoff state, during
// which s_axis_tready is low. The output register holds one result while the
// core works on the next pulse; the core waits only if that register is full.
// Reset clears config to defaults and all channel samples to not valid.
module rc_pulse_width_decoder_top #(
  parameter int FRACTION_BITS = rcpwd_pkg::FRACTION_BITS_DEF,
  parameter int OUT_TDATA_W   = ((rcpwd_pkg::CHANNEL_W + FRACTION_BITS + 1 + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // channel, timestamp, pin_level
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rcpwd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // out_channel, fraction
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_TDATA_W-1:0]             m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcpwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rcpwd_pkg::TICK_W-1:0]       cfg_data
);
  import rcpwd_pkg::*;

  localparam int FRAC_W = FRACTION_BITS + 1;

  cfg_regs_t cfg;

  logic [TICK_W-1:0]       last_edge_time [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] last_level;
  logic [NUM_CHANNELS-1:0] sample_valid;

  logic [CHANNEL_W-1:0] in_channel;
  logic [TICK_W-1:0]    in_timestamp;
  logic                 in_level;
  logic                 accept, enabled, active, pulse_done;

  job_t                 job;
  logic                 core_idle, core_start;
  logic                 res_valid, res_ready;
  logic [CHANNEL_W-1:0] res_channel;
  logic [FRAC_W-1:0]    res_fraction;
  logic [OUT_TDATA_W-1:0] m_tdata_next;

  // configuration writes, always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.legal_low      <= LEGAL_LOW_RST;
      cfg.legal_high     <= LEGAL_HIGH_RST;
      cfg.span_low       <= SPAN_LOW_RST;
      cfg.span_high      <= SPAN_HIGH_RST;
      cfg.channel_enable <= ENABLE_RST;
      cfg.invert_level   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEGAL_LOW:  cfg.legal_low      <= cfg_data;
        REG_LEGAL_HIGH: cfg.legal_high     <= cfg_data;
        REG_SPAN_LOW:   cfg.span_low       <= cfg_data;
        REG_SPAN_HIGH:  cfg.span_high      <= cfg_data;
        REG_ENABLE:     cfg.channel_enable <= cfg_data[ENABLE_W-1:0];
        REG_INVERT:     cfg.invert_level   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input request decode
  assign in_channel   = s_axis_tdata[CHANNEL_W-1:0];
  assign in_timestamp = s_axis_tdata[IN_TS_LSB +: TICK_W];
  assign in_level     = s_axis_tdata[IN_LVL_BIT];

  assign s_axis_tready = core_idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign enabled       = cfg.channel_enable[in_channel];
  assign active        = ~cfg.invert_level;
  assign pulse_done    = sample_valid[in_channel] && (last_level[in_channel] == active)
                         && (in_level != active);

  assign core_start    = accept && enabled && pulse_done;
  assign job.channel   = in_channel;
  assign job.timestamp = in_timestamp;
  assign job.last_time = last_edge_time[in_channel];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= '0;
      last_level   <= '0;
    end else if (accept && enabled) begin
      sample_valid[in_channel] <= 1'b1;
      last_level[in_channel]   <= in_level;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && enabled) begin
      last_edge_time[in_channel] <= in_timestamp;
    end
  end

  rcpwd_core #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (core_start),
    .job          (job),
    .idle         (core_idle),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_channel  (res_channel),
    .res_fraction (res_fraction)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    m_tdata_next = '0;
    m_tdata_next[CHANNEL_W-1:0]       = res_channel;
    m_tdata_next[CHANNEL_W +: FRAC_W] = res_fraction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= m_tdata_next;
    end
  end

endmodule
